>>> hdl/assert_macros.svh
// Assertion helpers for the RTL; only lsc_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSC_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lsc assertion failed");
`define LSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsc assertion failed");
`else
`define LSC_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define LSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/lsc_pkg.sv
`default_nettype none
package lsc_pkg;
   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int MAX_WORDS   = 64;
   localparam int WIDX_W      = $clog2(MAX_WORDS);
   localparam int WCNT_W      = WIDX_W + 1;
   localparam int STORE_DEPTH = SLOTS * MAX_WORDS;
   localparam int STORE_AW    = SLOT_W + WIDX_W;
   localparam int DATA_W      = 64;
   localparam int SECTOR_W    = 32;
   localparam int TDATA_W     = 104;
   localparam int CSR_W       = 7;
   localparam int CSR_SW_W    = 7;
   localparam int CSR_SL_W    = 5;

   localparam logic CSR_SECTOR_WORDS = 1'b0;
   localparam logic CSR_SLOTS_IN_USE = 1'b1;

   localparam logic [1:0] ACT_READ   = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_FILL   = 2'd2;
   localparam logic [1:0] ACT_STATUS = 2'd3;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_BREAD  = 2'd1;
   localparam logic [1:0] KIND_BWRITE = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_FILL  = 2'd1,
      OP_WRITE = 2'd2,
      OP_WSTAT = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]          action;
      logic [SECTOR_W-1:0] sector;
      logic [DATA_W-1:0]   data;
      logic                last;
      logic                ok;
   } item_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SECTOR_W-1:0] sector;
      logic [DATA_W-1:0]   data;
      logic                hit;
      logic                status;
      logic                last;
   } res_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;
endpackage
`default_nettype wire

>>> hdl/lsc_ram.sv
`default_nettype none
module lsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> hdl/lsc_front.sv
`default_nettype none
module lsc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [103:0]      req_tdata,
   input  wire logic              req_tlast,
   input  wire logic [1:0]        req_tuser,
   output lsc_pkg::queue_type     q_head,
   input  wire logic              q_pop
);
   import lsc_pkg::*;

   item_type   ent_ff [2];
   item_type   ent_in [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   item_type   new_item;

   // unpack the word into an item
   always_comb begin
      new_item.action = req_tuser;
      new_item.sector = req_tdata[31:0];
      new_item.data   = req_tdata[95:32];
      new_item.last   = req_tlast;
      new_item.ok     = req_tdata[96];
   end

   assign req_tready   = (count_ff != 2'd2);
   assign push         = req_tvalid && req_tready;
   assign pop          = q_pop && (count_ff != 2'd0);
   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.item  = ent_ff[rd_ptr_ff];

   always_comb begin
      ent_in    = ent_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         ent_in[wr_ptr_ff] = new_item;
         wr_ptr_in         = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

>>> hdl/lsc_back.sv
`default_nettype none
`include "assert_macros.svh"
module lsc_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lsc_pkg::queue_type           q_head,
   output logic                              q_pop,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [lsc_pkg::CSR_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output lsc_pkg::res_type                  rsp_res
);
   import lsc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_SINGLE = 5'b00100,
      ST_SRD    = 5'b01000,
      ST_SWAIT  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   logic [SECTOR_W-1:0]  tag_ff [SLOTS];
   logic [SECTOR_W-1:0]  tag_in [SLOTS];
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOT_W-1:0]    age_ff [SLOTS];
   logic [SLOT_W-1:0]    age_in [SLOTS];
   op_type               pend_op_ff, pend_op_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [SECTOR_W-1:0]  pend_sector_ff, pend_sector_in;
   logic [WCNT_W-1:0]    wcount_ff, wcount_in;
   logic                 pend_hit_ff, pend_hit_in;
   logic [CSR_SW_W-1:0]  sector_words_ff, sector_words_in;
   logic [CSR_SL_W-1:0]  slots_ff, slots_in;
   logic [SLOT_W-1:0]    s_slot_ff, s_slot_in;
   logic [1:0]           s_kind_ff, s_kind_in;
   logic [SECTOR_W-1:0]  s_sector_ff, s_sector_in;
   logic                 s_hit_ff, s_hit_in;
   logic [WCNT_W-1:0]    s_idx_ff, s_idx_in;
   res_type              single_ff, single_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   res_type              rsp_ff, rsp_in;

   logic [WCNT_W-1:0]    eff_words;
   logic [CNT_W-1:0]     eff_slots;
   logic [SLOTS-1:0]     hit_vec, free_vec, old_vec;
   logic                 hit_any, free_any;
   logic [SLOT_W-1:0]    hit_idx, free_idx, old_idx;
   logic                 ram_we;
   logic [STORE_AW-1:0]  ram_waddr;
   logic [DATA_W-1:0]    ram_rdata;
   logic                 out_free;

   // clamp the registers to their useful ranges
   always_comb begin
      if (sector_words_ff == '0) begin
         eff_words = WCNT_W'(1);
      end else if (sector_words_ff > CSR_SW_W'(MAX_WORDS)) begin
         eff_words = WCNT_W'(MAX_WORDS);
      end else begin
         eff_words = WCNT_W'(sector_words_ff);
      end
      if (slots_ff == '0) begin
         eff_slots = CNT_W'(1);
      end else if (slots_ff > CSR_SL_W'(SLOTS)) begin
         eff_slots = CNT_W'(SLOTS);
      end else begin
         eff_slots = CNT_W'(slots_ff);
      end
   end

   // parallel tag match and slot search
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      old_idx  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_vec[i]  = valid_ff[i] && (tag_ff[i] == item_ff.sector);
         free_vec[i] = !valid_ff[i] && (CNT_W'(i) < eff_slots);
         old_vec[i]  = valid_ff[i] && (age_ff[i] == SLOT_W'(eff_slots - CNT_W'(1)));
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) hit_idx = SLOT_W'(i);
         if (free_vec[i]) free_idx = SLOT_W'(i);
         if (old_vec[i]) old_idx = SLOT_W'(i);
      end
      hit_any  = |hit_vec;
      free_any = |free_vec;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [SLOT_W-1:0]   w_slot;
      logic [WCNT_W-1:0]   w_base;
      logic                w_hit;
      logic [SECTOR_W-1:0] w_sec;
      logic                w_take;
      logic [SLOT_W-1:0]   a;

      state_in        = state_ff;
      item_in         = item_ff;
      tag_in          = tag_ff;
      valid_in        = valid_ff;
      age_in          = age_ff;
      pend_op_in      = pend_op_ff;
      pend_slot_in    = pend_slot_ff;
      pend_sector_in  = pend_sector_ff;
      wcount_in       = wcount_ff;
      pend_hit_in     = pend_hit_ff;
      sector_words_in = sector_words_ff;
      slots_in        = slots_ff;
      s_slot_in       = s_slot_ff;
      s_kind_in       = s_kind_ff;
      s_sector_in     = s_sector_ff;
      s_hit_in        = s_hit_ff;
      s_idx_in        = s_idx_ff;
      single_in       = single_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      q_pop           = 1'b0;
      ram_we          = 1'b0;
      ram_waddr       = '0;
      w_slot          = pend_slot_ff;
      w_base          = wcount_ff;
      w_hit           = pend_hit_ff;
      w_sec           = pend_sector_ff;
      w_take          = 1'b0;
      a               = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               item_in  = q_head.item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (item_ff.action)
               ACT_READ: begin
                  if (pend_op_ff == OP_IDLE) begin
                     if (hit_any) begin
                        a = age_ff[hit_idx];
                        for (int i = 0; i < SLOTS; i++) begin
                           if (valid_ff[i] && age_ff[i] < a) age_in[i] = age_ff[i] + 1'b1;
                        end
                        age_in[hit_idx] = '0;
                        s_slot_in   = hit_idx;
                        s_kind_in   = KIND_DATA;
                        s_sector_in = item_ff.sector;
                        s_hit_in    = 1'b1;
                        s_idx_in    = '0;
                        state_in    = ST_SRD;
                     end else begin
                        if (free_any) begin
                           pend_slot_in = free_idx;
                        end else begin
                           // evict the oldest; nothing is older, so no ages move
                           pend_slot_in      = old_idx;
                           valid_in[old_idx] = 1'b0;
                           age_in[old_idx]   = '0;
                        end
                        pend_sector_in   = item_ff.sector;
                        wcount_in        = '0;
                        pend_op_in       = OP_FILL;
                        single_in.kind   = KIND_BREAD;
                        single_in.sector = item_ff.sector;
                        single_in.data   = '0;
                        single_in.hit    = 1'b0;
                        single_in.status = 1'b0;
                        single_in.last   = 1'b1;
                        state_in         = ST_SINGLE;
                     end
                  end
               end
               ACT_WRITE: begin
                  if (pend_op_ff == OP_IDLE) begin
                     w_take         = 1'b1;
                     w_base         = '0;
                     w_sec          = item_ff.sector;
                     pend_sector_in = item_ff.sector;
                     pend_op_in     = OP_WRITE;
                     if (hit_any) begin
                        a = age_ff[hit_idx];
                        for (int i = 0; i < SLOTS; i++) begin
                           if (valid_ff[i] && age_ff[i] < a) age_in[i] = age_ff[i] + 1'b1;
                        end
                        age_in[hit_idx] = '0;
                        w_slot = hit_idx;
                        w_hit  = 1'b1;
                     end else begin
                        w_slot = free_any ? free_idx : old_idx;
                        w_hit  = 1'b0;
                        for (int i = 0; i < SLOTS; i++) begin
                           if (valid_ff[i] && SLOT_W'(i) != w_slot) begin
                              age_in[i] = age_ff[i] + 1'b1;
                           end
                        end
                        valid_in[w_slot] = 1'b1;
                        tag_in[w_slot]   = item_ff.sector;
                        age_in[w_slot]   = '0;
                     end
                     pend_slot_in = w_slot;
                     pend_hit_in  = w_hit;
                  end else if (pend_op_ff == OP_WRITE) begin
                     w_take = 1'b1;
                  end
                  if (w_take) begin
                     wcount_in = w_base;
                     if (w_base < eff_words) begin
                        ram_we    = 1'b1;
                        ram_waddr = {w_slot, w_base[WIDX_W-1:0]};
                        wcount_in = w_base + 1'b1;
                     end
                     if (item_ff.last) begin
                        if (w_hit) begin
                           pend_op_in       = OP_IDLE;
                           single_in.kind   = KIND_DONE;
                           single_in.sector = w_sec;
                           single_in.data   = '0;
                           single_in.hit    = 1'b1;
                           single_in.status = 1'b0;
                           single_in.last   = 1'b1;
                           state_in         = ST_SINGLE;
                        end else begin
                           pend_op_in  = OP_WSTAT;
                           s_slot_in   = w_slot;
                           s_kind_in   = KIND_BWRITE;
                           s_sector_in = w_sec;
                           s_hit_in    = 1'b0;
                           s_idx_in    = '0;
                           state_in    = ST_SRD;
                        end
                     end
                  end
               end
               ACT_FILL: begin
                  if (pend_op_ff == OP_FILL && wcount_ff < eff_words) begin
                     ram_we    = 1'b1;
                     ram_waddr = {pend_slot_ff, wcount_ff[WIDX_W-1:0]};
                     wcount_in = wcount_ff + 1'b1;
                  end
               end
               ACT_STATUS: begin
                  if (pend_op_ff == OP_FILL) begin
                     pend_op_in = OP_IDLE;
                     if (item_ff.ok) begin
                        for (int i = 0; i < SLOTS; i++) begin
                           if (valid_ff[i] && SLOT_W'(i) != pend_slot_ff) begin
                              age_in[i] = age_ff[i] + 1'b1;
                           end
                        end
                        valid_in[pend_slot_ff] = 1'b1;
                        tag_in[pend_slot_ff]   = pend_sector_ff;
                        age_in[pend_slot_ff]   = '0;
                        s_slot_in   = pend_slot_ff;
                        s_kind_in   = KIND_DATA;
                        s_sector_in = pend_sector_ff;
                        s_hit_in    = 1'b0;
                        s_idx_in    = '0;
                        state_in    = ST_SRD;
                     end else begin
                        single_in.kind   = KIND_DONE;
                        single_in.sector = pend_sector_ff;
                        single_in.data   = '0;
                        single_in.hit    = 1'b0;
                        single_in.status = 1'b1;
                        single_in.last   = 1'b1;
                        state_in         = ST_SINGLE;
                     end
                  end else if (pend_op_ff == OP_WSTAT) begin
                     pend_op_in = OP_IDLE;
                     if (!item_ff.ok && valid_ff[pend_slot_ff]) begin
                        // unlink the slot and close the age gap
                        a = age_ff[pend_slot_ff];
                        for (int i = 0; i < SLOTS; i++) begin
                           if (valid_ff[i] && age_ff[i] > a) age_in[i] = age_ff[i] - 1'b1;
                        end
                        valid_in[pend_slot_ff] = 1'b0;
                        age_in[pend_slot_ff]   = '0;
                     end
                     single_in.kind   = KIND_DONE;
                     single_in.sector = pend_sector_ff;
                     single_in.data   = '0;
                     single_in.hit    = 1'b0;
                     single_in.status = !item_ff.ok;
                     single_in.last   = 1'b1;
                     state_in         = ST_SINGLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = single_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_SRD: begin
            state_in = ST_SWAIT;
         end
         ST_SWAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in.kind   = s_kind_ff;
               rsp_in.sector = s_sector_ff;
               rsp_in.data   = ram_rdata;
               rsp_in.hit    = s_hit_ff;
               rsp_in.status = 1'b0;
               rsp_in.last   = (s_idx_ff + 1'b1 == eff_words);
               s_idx_in      = s_idx_ff + 1'b1;
               state_in      = rsp_in.last ? ST_IDLE : ST_SRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_SECTOR_WORDS: begin
               sector_words_in = csr_wdata[CSR_SW_W-1:0];
            end
            CSR_SLOTS_IN_USE: begin
               slots_in    = csr_wdata[CSR_SL_W-1:0];
               valid_in    = '0;
               pend_op_in  = OP_IDLE;
               wcount_in   = '0;
               pend_hit_in = 1'b0;
               for (int i = 0; i < SLOTS; i++) begin
                  age_in[i] = '0;
               end
            end
            default: begin
               sector_words_in = sector_words_ff;
            end
         endcase
      end
   end

   lsc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (item_ff.data),
      .raddr ({s_slot_ff, s_idx_ff[WIDX_W-1:0]}),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      tag_ff      <= tag_in;
      s_slot_ff   <= s_slot_in;
      s_kind_ff   <= s_kind_in;
      s_sector_ff <= s_sector_in;
      s_hit_ff    <= s_hit_in;
      s_idx_ff    <= s_idx_in;
      single_ff   <= single_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         valid_ff        <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            age_ff[i] <= '0;
         end
         pend_op_ff      <= OP_IDLE;
         pend_slot_ff    <= '0;
         pend_sector_ff  <= '0;
         wcount_ff       <= '0;
         pend_hit_ff     <= 1'b0;
         sector_words_ff <= CSR_SW_W'(MAX_WORDS);
         slots_ff        <= CSR_SL_W'(SLOTS);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         age_ff          <= age_in;
         pend_op_ff      <= pend_op_in;
         pend_slot_ff    <= pend_slot_in;
         pend_sector_ff  <= pend_sector_in;
         wcount_ff       <= wcount_in;
         pend_hit_ff     <= pend_hit_in;
         sector_words_ff <= sector_words_in;
         slots_ff        <= slots_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;

   `LSC_ASSERT_ALWAYS(a_valid_within_enabled, clock, reset, $countones(valid_ff) <= eff_slots)
   `LSC_ASSERT_IMPLY(a_fill_slot_free, clock, reset, pend_op_ff == OP_FILL, !valid_ff[pend_slot_ff])
   `LSC_ASSERT_IMPLY(a_stream_in_sector, clock, reset, state_ff == ST_SWAIT, s_idx_ff < eff_words)
endmodule
`default_nettype wire

>>> hdl/lru_sector_cache_top.sv
`default_nettype none
// Fully associative sector cache with LRU replacement in front of a backing store.
// req_ channel: one word per read request, write data word, backing fill word or
//   backing status (req_tuser = action). req_tlast ends a write run.
// rsp_ channel: data words to the requester, backing read requests, backing write
//   words and done words (rsp_tuser = kind); rsp_tlast marks the last word caused
//   by one request word.
// csr_ port: index 0 sets words per sector, index 1 sets slots in use and frees
//   every slot. Write it only while the block is idle.
// Flow: an idle back end pops a request word in the cycle after it is accepted and
//   decodes it in ST_EXEC in the next cycle; it pops no new word until it is done
//   with the last. A single-word answer goes to the output register from ST_SINGLE;
//   a sector streams word by word, each store word read through the registered read
//   port in ST_SRD and sent from ST_SWAIT; a word with no answer ends in ST_EXEC.
// A two-word queue parts the front from the back; req_tready drops when it is full.
// A stalled rsp_ channel holds the output register and stops the back end when it has
//   a word to send; the front keeps filling its queue.
// Reset clears all slots and the pending operation; the store contents are not
//   cleared and need no clearing pass.
module lru_sector_cache_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // [31:0] sector_number, [95:32] in_data, [96] backing_ok, rest zero
   input  wire logic [lsc_pkg::TDATA_W-1:0] req_tdata,
   input  wire logic                        req_tlast,
   // [1:0] action
   input  wire logic [1:0]                  req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // [31:0] out_sector, [95:32] out_data, [96] hit, [97] status, rest zero
   output logic      [lsc_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   // [1:0] out_kind
   output logic      [1:0]                  rsp_tuser,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [lsc_pkg::CSR_W-1:0]   csr_wdata
);
   import lsc_pkg::*;

   queue_type q_head;
   logic      q_pop;
   res_type   res;

   // accept and queue request words
   lsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   // look up, update LRU state and stream sectors
   lsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (res)
   );

   // pack the result word
   assign rsp_tdata = {6'b0, res.status, res.hit, res.data, res.sector};
   assign rsp_tlast = res.last;
   assign rsp_tuser = res.kind;
endmodule
`default_nettype wire

>>> sim/lru_sector_cache_top_test.sv
`timescale 1ns / 1ps

module lru_sector_cache_top_test;
   import lsc_pkg::*;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // [31:0] sector_number, [95:32] in_data, [96] backing_ok, rest zero
   logic [TDATA_W-1:0]  req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   // [1:0] action
   logic [1:0]          req_tuser  = ACT_READ;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // [31:0] out_sector, [95:32] out_data, [96] hit, [97] status, rest zero
   logic [TDATA_W-1:0]  rsp_tdata;
   logic                rsp_tlast;
   // [1:0] out_kind
   logic [1:0]          rsp_tuser;
   logic                csr_we     = 1'b0;
   logic                csr_index  = CSR_SECTOR_WORDS;
   logic [CSR_W-1:0]    csr_wdata  = '0;

   lru_sector_cache_top dut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the cache: slot tags, LRU ages, sector store and the
   // operation in flight. written_w tracks which store words hold real data.
   logic [SECTOR_W-1:0] tag_r   [SLOTS];
   bit                  valid_r [SLOTS];
   int                  age_r   [SLOTS];
   logic [DATA_W-1:0]   store_r [SLOTS][MAX_WORDS];
   bit                  written_w [SLOTS][MAX_WORDS];
   op_type              pend_op = OP_IDLE;
   int                  pend_slot, word_cnt;
   logic [SECTOR_W-1:0] pend_sector;
   bit                  pend_hit;
   int                  reg_words = 64, reg_slots = 16;

   res_type rsp_due[$];     // answers still owed by the block, oldest first
   res_type seen;
   int      errors = 0;
   int      words_sent = 0;
   bit      quiet = 1'b0;   // no idling on either side
   int      long_hold = 0;  // receiver hold-off, in cycles

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         valid_r[i] = 1'b0;
         age_r[i] = 0;
         for (int j = 0; j < MAX_WORDS; j++) written_w[i][j] = 1'b0;
      end
   end

   // Clamp the raw register values to what the block actually uses.
   function automatic int n_words();
      return (reg_words < 1) ? 1 : (reg_words > MAX_WORDS) ? MAX_WORDS : reg_words;
   endfunction

   function automatic int n_slots();
      return (reg_slots < 1) ? 1 : (reg_slots > SLOTS) ? SLOTS : reg_slots;
   endfunction

   function automatic int find_slot(logic [SECTOR_W-1:0] tag);
      for (int i = 0; i < n_slots(); i++)
         if (valid_r[i] && tag_r[i] == tag) return i;
      return -1;
   endfunction

   // Slot a request for this sector lands in: the hit, the lowest free slot,
   // or else the oldest one.
   function automatic int peek_slot(logic [SECTOR_W-1:0] tag);
      int h, best;
      h = find_slot(tag);
      if (h >= 0) return h;
      for (int i = 0; i < n_slots(); i++)
         if (!valid_r[i]) return i;
      best = 0;
      for (int i = 1; i < n_slots(); i++)
         if (age_r[i] > age_r[best]) best = i;
      return best;
   endfunction

   function automatic void touch_slot(int s);
      int a;
      a = age_r[s];
      for (int i = 0; i < n_slots(); i++)
         if (i != s && valid_r[i] && age_r[i] < a) age_r[i]++;
      age_r[s] = 0;
   endfunction

   function automatic void install_slot(int s, logic [SECTOR_W-1:0] tag);
      for (int i = 0; i < n_slots(); i++)
         if (i != s && valid_r[i]) age_r[i]++;
      valid_r[s] = 1'b1;
      tag_r[s] = tag;
      age_r[s] = 0;
   endfunction

   function automatic void release_slot(int s);
      int a;
      if (!valid_r[s]) return;
      a = age_r[s];
      valid_r[s] = 1'b0;
      age_r[s] = 0;
      for (int i = 0; i < n_slots(); i++)
         if (valid_r[i] && age_r[i] > a) age_r[i]--;
   endfunction

   // Only called on a miss: evict the oldest slot when none is free.
   function automatic int claim_slot(logic [SECTOR_W-1:0] tag);
      int s;
      s = peek_slot(tag);
      if (valid_r[s]) release_slot(s);
      return s;
   endfunction

   function automatic void owe(logic [1:0] kind, logic [SECTOR_W-1:0] sec,
                               logic [DATA_W-1:0] d, bit hit, bit status, bit last);
      res_type r;
      r.kind = kind;
      r.sector = sec;
      r.data = d;
      r.hit = hit;
      r.status = status;
      r.last = last;
      rsp_due.push_back(r);
   endfunction

   function automatic void owe_sector(int s, logic [1:0] kind,
                                      logic [SECTOR_W-1:0] sec, bit hit);
      for (int i = 0; i < n_words(); i++)
         owe(kind, sec, store_r[s][i], hit, 1'b0, i + 1 == n_words());
   endfunction

   function automatic void keep_word(logic [DATA_W-1:0] d);
      if (word_cnt < n_words()) begin
         store_r[pend_slot][word_cnt] = d;
         written_w[pend_slot][word_cnt] = 1'b1;
         word_cnt++;
      end
   endfunction

   // Advance the shadow cache by one accepted request word and queue its answers.
   function automatic void predict_cache(logic [1:0] act, logic [SECTOR_W-1:0] sec,
                                         logic [DATA_W-1:0] d, bit last, bit ok);
      int h;
      case (act)
         ACT_READ: begin
            if (pend_op != OP_IDLE) return;
            h = find_slot(sec);
            if (h >= 0) begin
               touch_slot(h);
               owe_sector(h, KIND_DATA, sec, 1'b1);
               return;
            end
            pend_slot = claim_slot(sec);
            pend_sector = sec;
            word_cnt = 0;
            pend_op = OP_FILL;
            owe(KIND_BREAD, sec, '0, 1'b0, 1'b0, 1'b1);
         end
         ACT_WRITE: begin
            if (pend_op == OP_IDLE) begin
               h = find_slot(sec);
               pend_sector = sec;
               word_cnt = 0;
               if (h >= 0) begin
                  touch_slot(h);
                  pend_slot = h;
                  pend_hit = 1'b1;
               end else begin
                  pend_slot = claim_slot(sec);
                  install_slot(pend_slot, sec);
                  pend_hit = 1'b0;
               end
               pend_op = OP_WRITE;
            end else if (pend_op != OP_WRITE) begin
               return;
            end
            keep_word(d);
            if (!last) return;
            if (pend_hit) begin
               pend_op = OP_IDLE;
               owe(KIND_DONE, pend_sector, '0, 1'b1, 1'b0, 1'b1);
            end else begin
               pend_op = OP_WSTAT;
               owe_sector(pend_slot, KIND_BWRITE, pend_sector, 1'b0);
            end
         end
         ACT_FILL: begin
            if (pend_op == OP_FILL) keep_word(d);
         end
         default: begin
            if (pend_op == OP_FILL) begin
               pend_op = OP_IDLE;
               if (ok) begin
                  install_slot(pend_slot, pend_sector);
                  owe_sector(pend_slot, KIND_DATA, pend_sector, 1'b0);
               end else begin
                  owe(KIND_DONE, pend_sector, '0, 1'b0, 1'b1, 1'b1);
               end
            end else if (pend_op == OP_WSTAT) begin
               pend_op = OP_IDLE;
               if (!ok) release_slot(pend_slot);
               owe(KIND_DONE, pend_sector, '0, 1'b0, !ok, 1'b1);
            end
         end
      endcase
   endfunction

   // Send one request word; the shadow cache advances once it is taken.
   task automatic send_word(logic [1:0] act, logic [SECTOR_W-1:0] sec,
                            logic [DATA_W-1:0] d, bit last, bit ok);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, ok, d, sec};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_cache(act, sec, d, last, ok);
      words_sent++;
   endtask

   function automatic logic [DATA_W-1:0] rand_data();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Fewest words a run must bring so that no unwritten store word is read back.
   function automatic int min_run(logic [SECTOR_W-1:0] sec, bit is_write);
      int s, mn;
      s = peek_slot(sec);
      mn = 0;
      for (int i = 0; i < n_words(); i++)
         if (!written_w[s][i]) mn = i + 1;
      return (is_write && mn == 0) ? 1 : mn;
   endfunction

   // Read request; on a miss feed n fill words, with the odd stray word
   // mixed in, then the backing status.
   task automatic do_read(logic [SECTOR_W-1:0] sec, int n, bit ok);
      bit miss;
      miss = find_slot(sec) < 0;
      send_word(ACT_READ, sec, rand_data(), $urandom_range(0, 1), $urandom_range(0, 1));
      if (!miss) return;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            send_word($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, $urandom, rand_data(),
                      $urandom_range(0, 1), $urandom_range(0, 1));
            words_sent--;
         end
         send_word(ACT_FILL, $urandom, rand_data(), $urandom_range(0, 1),
                   $urandom_range(0, 1));
      end
      send_word(ACT_STATUS, $urandom, rand_data(), $urandom_range(0, 1), ok);
   endtask

   // Write run of n words; a miss waits for the backing status.
   task automatic do_write(logic [SECTOR_W-1:0] sec, int n, bit ok);
      bit miss;
      miss = find_slot(sec) < 0;
      for (int i = 0; i < n; i++)
         send_word(ACT_WRITE, (i == 0) ? sec : $urandom, rand_data(), i == n - 1,
                   $urandom_range(0, 1));
      if (miss) send_word(ACT_STATUS, $urandom, rand_data(), $urandom_range(0, 1), ok);
   endtask

   // Drop valid, drain every owed answer, then give the back end time to go idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SECTOR_WORDS) begin
         reg_words = val;
      end else begin
         reg_slots = val[CSR_SL_W-1:0];
         for (int i = 0; i < SLOTS; i++) begin
            valid_r[i] = 1'b0;
            age_r[i] = 0;
         end
         pend_op = OP_IDLE;
         word_cnt = 0;
         pend_hit = 1'b0;
      end
   endtask

   // Slots are always freed after a size change so no hit can read past
   // what was stored under the old size.
   task automatic set_geometry(logic [CSR_W-1:0] words, logic [CSR_W-1:0] slots);
      write_csr(CSR_SECTOR_WORDS, words);
      write_csr(CSR_SLOTS_IN_USE, slots);
   endtask

   // Mostly whole read and write transactions on a small sector pool so
   // hits, evictions and failures keep coming; the rest is stray words.
   task automatic random_traffic(int n);
      int stop, r, len;
      logic [SECTOR_W-1:0] sec;
      stop = words_sent + n;
      while (words_sent < stop) begin
         r = $urandom_range(0, 99);
         sec = ($urandom_range(0, 9) == 0) ? $urandom
                                           : 32'h100 + $urandom_range(0, 3 * n_slots());
         if (r < 45) begin
            len = $urandom_range(min_run(sec, 1'b0), n_words() + 2);
            do_read(sec, len, $urandom_range(0, 6) != 0);
         end else if (r < 82) begin
            len = $urandom_range(min_run(sec, 1'b1), n_words() + 2);
            do_write(sec, len, $urandom_range(0, 5) != 0);
         end else begin
            send_word($urandom_range(0, 1) ? ACT_FILL : ACT_STATUS, $urandom, rand_data(),
                      $urandom_range(0, 1), $urandom_range(0, 1));
            words_sent--;
         end
      end
      settle();
   endtask

   task automatic test_directed();
      set_geometry(2, 2);
      do_write(32'h0, 2, 1'b1);          // write miss, sent to backing store
      do_read(32'h0, 0, 1'b1);           // read hit
      do_read(32'hFFFF_FFFF, 3, 1'b1);   // miss with an overlong fill
      do_read(32'h5, 2, 1'b0);           // evicts the oldest, backing read fails
      send_word(ACT_STATUS, 32'h0, '1, 1'b1, 1'b1);   // status while idle: dropped
      send_word(ACT_FILL, 32'h0, '0, 1'b0, 1'b0);     // fill while idle: dropped
      do_write(32'hFFFF_FFFF, 1, 1'b1);  // short write run on a hit
      do_write(32'h7, 2, 1'b0);          // write miss, backing write fails
      do_read(32'h7, 2, 1'b1);           // unlinked slot misses again
      settle();
   endtask

   task automatic test_clamped_registers();
      set_geometry(4, 3);
      random_traffic(130);
      set_geometry(1, 1);
      random_traffic(40);
      set_geometry(0, 0);                // both clamp up to one
      random_traffic(30);
      set_geometry(127, 31);             // both clamp down to the maximum
      random_traffic(40);
   endtask

   task automatic test_backpressure();
      set_geometry(8, 16);
      long_hold = 400;
      random_traffic(80);
   endtask

   task automatic test_full_rate();
      set_geometry(3, 5);
      quiet = 1'b1;
      random_traffic(130);
   endtask

   // Receiver: random stall bursts, one long hold-off on request.
   always begin
      @(posedge clock);
      if (long_hold > 0) begin
         rsp_tready <= 1'b0;
         repeat (long_hold) @(posedge clock);
         long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // Compare every answer word with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            errors++;
            $display("%0t unexpected word: kind %0d tdata %h last %b", $time, rsp_tuser,
                     rsp_tdata, rsp_tlast);
         end else begin
            seen = rsp_due.pop_front();
            if (rsp_tuser !== seen.kind) begin
               errors++;
               $display("%0t kind: expected %0d got %0d", $time, seen.kind, rsp_tuser);
            end
            if (rsp_tdata[31:0] !== seen.sector) begin
               errors++;
               $display("%0t sector: expected %h got %h", $time, seen.sector,
                        rsp_tdata[31:0]);
            end
            if (rsp_tdata[95:32] !== seen.data) begin
               errors++;
               $display("%0t data: expected %h got %h", $time, seen.data, rsp_tdata[95:32]);
            end
            if (rsp_tdata[96] !== seen.hit) begin
               errors++;
               $display("%0t hit: expected %b got %b", $time, seen.hit, rsp_tdata[96]);
            end
            if (rsp_tdata[97] !== seen.status) begin
               errors++;
               $display("%0t status: expected %b got %b", $time, seen.status, rsp_tdata[97]);
            end
            if (rsp_tlast !== seen.last) begin
               errors++;
               $display("%0t last: expected %b got %b", $time, seen.last, rsp_tlast);
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_clamped_registers();
      test_backpressure();
      test_full_rate();
      settle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #20_000_000;
      $display("%0t timeout, %0d answer words still owed", $time, rsp_due.size());
      $display("*** FAILED ***");
      $finish;
   end
endmodule

>>> lru_sector_cache_top.f
+incdir+hdl
hdl/lsc_pkg.sv
hdl/lsc_ram.sv
hdl/lsc_front.sv
hdl/lsc_back.sv
hdl/lru_sector_cache_top.sv
sim/lru_sector_cache_top_test.sv
